[rtl/nrc_pkg.sv]
// Package: payload structs, register indexes and status codes for route compute.
package nrc_pkg;

    typedef struct packed {
        logic        mode;
        logic [1:0]  vnet;
        logic [5:0]  dst_id;
        logic [63:0] dest_mask;
        logic [2:0]  link_index;
        logic [7:0]  link_wt;
    } t_in_item;

    typedef struct packed {
        logic [3:0] out_port;
        logic [1:0] status;
    } t_out_item;

    localparam logic [1:0] ST_ROUTED   = 2'd0;
    localparam logic [1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [1:0] ST_WRITTEN  = 2'd2;

    localparam logic [1:0] ALG_TABLE = 2'd0;
    localparam logic [1:0] ALG_XY    = 2'd1;
    localparam logic [1:0] ALG_XYZ   = 2'd2;
    localparam logic [1:0] ALG_RING  = 2'd3;

    localparam logic [2:0] REG_ALGORITHM = 3'd0;
    localparam logic [2:0] REG_MY_ID     = 3'd1;
    localparam logic [2:0] REG_ROWS      = 3'd2;
    localparam logic [2:0] REG_COLS      = 3'd3;
    localparam logic [2:0] REG_COUNT     = 3'd4;
    localparam logic [2:0] REG_ORDERED   = 3'd5;
    localparam logic [2:0] REG_PORT_MAP  = 3'd6;

    localparam logic [2:0] DIR_EAST  = 3'd0;
    localparam logic [2:0] DIR_WEST  = 3'd1;
    localparam logic [2:0] DIR_NORTH = 3'd2;
    localparam logic [2:0] DIR_SOUTH = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // divider command/result between top level and divider unit
    typedef struct packed {
        logic       start;
        logic [6:0] num;
        logic [6:0] den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [6:0] quo;
        logic [6:0] rem;
    } t_div_rsp;

endpackage

[rtl/nrc_ram.sv]
// Generic single-port-write, registered-read RAM.
module nrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/nrc_div.sv]
// Restoring divider, 7-bit operands, one quotient bit per cycle.
module nrc_div import nrc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [6:0] r_quo;
    logic [7:0] r_rem;
    logic [6:0] r_den;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       r_done;
    logic [7:0] n_trial;

    assign n_trial = {r_rem[6:0], r_quo[6]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_rem  <= 8'd0;
                r_den  <= i_req.den;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_den}) begin
                    r_rem <= n_trial - {1'b0, r_den};
                    r_quo <= {r_quo[5:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[5:0], 1'b0};
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[6:0];

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_rsp.done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("div done without busy");

    property p_rem_lt_den;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_rsp.done && r_den != 7'd0) |-> (r_rem < {1'b0, r_den});
    endproperty
    a_rem_lt_den: assert property (p_rem_lt_den) else $error("div remainder too large");

    property p_no_done_on_start;
        @(posedge i_clk) disable iff (!i_rst_n) i_req.start |=> !o_rsp.done;
    endproperty
    a_no_done_on_start: assert property (p_no_done_on_start) else $error("div done too early");
endmodule

[rtl/noc_route_compute_core.sv]
// Top level: route compute sequencer over the route mask memory and divider.
// A write returns its status straight from idle; table scans every link, then for unordered
// vnets a serial LFSR modulo picks among ties before the pick scan; XY and ring run the
// divider twice, XYZ four times.
// One transaction at a time: input stalls until the result is taken.
// Sync reset loads config, weights, LFSR 0xACE1; per-entry valid bits zero unwritten masks.
module noc_route_compute_core import nrc_pkg::*; #(
    parameter int NUM_VNETS = 4,
    parameter int NUM_LINKS = 8,
    parameter int DEST_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int DEPTH = NUM_VNETS * NUM_LINKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int CW    = $clog2(NUM_LINKS + 1);
    localparam logic [63:0] FIELD_MASK = {64{1'b1}} >> (64 - DEST_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EVAL, S_MOD, S_PICK, S_DSTART, S_DWAIT, S_DECIDE
    } t_state;

    t_state      r_state;
    logic [1:0]  r_alg;
    logic [5:0]  r_my_id;
    logic [6:0]  r_rows, r_cols, r_count;
    logic [3:0]  r_ordered;
    logic [23:0] r_pmap;
    logic [15:0] r_lfsr;
    logic [7:0]  r_wt [NUM_LINKS];
    logic [DEPTH-1:0] r_vld;

    t_in_item      r_in;
    logic [LW:0]   r_idx;
    logic          r_rd_v;
    logic          r_rd_ok;
    logic [LW-1:0] r_dlink;
    logic [NUM_LINKS-1:0] r_hit;
    logic [7:0]    r_best;
    logic [CW-1:0] r_cnt, r_pick, r_seen, r_acc;
    logic [3:0]    r_bit;
    logic [1:0]    r_step;
    logic [6:0]    r_dnum, r_ma, r_mb, r_mz, r_da, r_db, r_dz;
    logic          r_ovalid;
    t_out_item     r_out;

    logic [63:0]   w_rdata, w_dmask;
    logic          w_hit, w_cand;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    logic [7:0]    w_wt;
    t_div_req      w_dreq;
    t_div_rsp      w_drsp;
    logic [6:0]    w_rows, w_cols, w_n, w_den;
    logic [7:0]    w_cw, w_ccw;
    logic          w_accept;
    logic [CW:0]   w_mod_t;
    logic [CW-1:0] w_mod;
    logic [3:0]    n_port;
    logic          n_ok;
    logic [15:0]   n_lfsr;

    function automatic logic [3:0] dir_port(input logic [23:0] map, input logic [2:0] d);
        return map[{d, 2'b00} +: 4];
    endfunction

    assign w_rows   = (r_rows == 7'd0) ? 7'd1 : r_rows;
    assign w_cols   = (r_cols == 7'd0) ? 7'd1 : r_cols;
    assign w_n      = (r_count == 7'd0) ? 7'd1 : r_count;
    assign w_den    = (r_alg == ALG_XY) ? w_cols : ((r_alg == ALG_XYZ) ? w_rows : w_n);
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign w_dmask  = i_item.dest_mask & FIELD_MASK;
    assign w_we = w_accept && i_item.mode && (32'(i_item.vnet) < NUM_VNETS)
                  && (32'(i_item.link_index) < NUM_LINKS);
    assign w_waddr = AW'((32'(i_item.vnet) * NUM_LINKS) + 32'(i_item.link_index));
    assign w_raddr = AW'((32'(r_in.vnet) * NUM_LINKS) + 32'(r_idx));
    assign n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    nrc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_masks (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_dmask),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    nrc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_wt   = r_wt[r_dlink];
    assign w_hit  = r_rd_ok && ((w_rdata & r_in.dest_mask & FIELD_MASK) != 64'd0);
    assign w_cand = r_hit[r_idx[LW-1:0]] && (r_wt[r_idx[LW-1:0]] == r_best);

    // restoring step of lfsr mod count, msb first
    assign w_mod_t = {r_acc, r_lfsr[r_bit]};
    assign w_mod   = (w_mod_t >= {1'b0, r_cnt}) ? CW'(w_mod_t - {1'b0, r_cnt})
                                                 : w_mod_t[CW-1:0];

    always_comb begin
        w_dreq = '0;
        if (r_state == S_DSTART) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = r_dnum;
            w_dreq.den   = w_den;
        end
    end

    // ring distances with both ids already reduced
    assign w_cw  = (r_da >= r_ma) ? ({1'b0, r_da} - {1'b0, r_ma})
                                  : ({1'b0, r_da} + {1'b0, w_n} - {1'b0, r_ma});
    assign w_ccw = (r_ma >= r_da) ? ({1'b0, r_ma} - {1'b0, r_da})
                                  : ({1'b0, r_ma} + {1'b0, w_n} - {1'b0, r_da});

    // final decision for mesh/ring; z coordinates stay zero in XY
    always_comb begin
        n_port = 4'd0;
        n_ok   = 1'b1;
        if (r_alg == ALG_RING) begin
            n_port = dir_port(r_pmap, (w_cw <= w_ccw) ? DIR_EAST : DIR_WEST);
        end else if (r_da != r_ma) begin
            n_port = dir_port(r_pmap, (r_da > r_ma) ? DIR_EAST : DIR_WEST);
        end else if (r_db != r_mb) begin
            n_port = dir_port(r_pmap, (r_db > r_mb) ? DIR_NORTH : DIR_SOUTH);
        end else if (r_dz != r_mz) begin
            n_port = dir_port(r_pmap, (r_dz > r_mz) ? DIR_UP : DIR_DOWN);
        end else begin
            n_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alg     <= ALG_TABLE;
            r_my_id   <= 6'd0;
            r_rows    <= 7'd4;
            r_cols    <= 7'd4;
            r_count   <= 7'd16;
            r_ordered <= 4'd0;
            r_pmap    <= 24'd0;
            r_lfsr    <= LFSR_SEED;
            r_vld     <= '0;
            r_ovalid  <= 1'b0;
            r_rd_v    <= 1'b0;
            for (int i = 0; i < NUM_LINKS; i++) r_wt[i] <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALGORITHM: r_alg     <= i_cfg_data[1:0];
                    REG_MY_ID:     r_my_id   <= i_cfg_data[5:0];
                    REG_ROWS:      r_rows    <= i_cfg_data[6:0];
                    REG_COLS:      r_cols    <= i_cfg_data[6:0];
                    REG_COUNT:     r_count   <= i_cfg_data[6:0];
                    REG_ORDERED:   r_ordered <= i_cfg_data[3:0];
                    REG_PORT_MAP:  r_pmap    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
                r_wt[LW'(i_item.link_index)] <= i_item.link_wt;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in   <= i_item;
                        r_idx  <= '0;
                        r_rd_v <= 1'b0;
                        r_cnt  <= '0;
                        r_best <= 8'd0;
                        r_step <= 2'd0;
                        r_dnum <= {1'b0, r_my_id};
                        r_mz   <= 7'd0;
                        r_dz   <= 7'd0;
                        if (i_item.mode) begin
                            r_out    <= '{out_port: 4'd0, status: ST_WRITTEN};
                            r_ovalid <= 1'b1;
                        end else if ((i_item.dst_id == r_my_id) || (r_alg == ALG_TABLE)) begin
                            if (32'(i_item.vnet) >= NUM_VNETS) begin
                                r_out    <= '{out_port: 4'd0, status: ST_NO_ROUTE};
                                r_ovalid <= 1'b1;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_SCAN: begin
                    // one mask read per cycle, data in the next cycle; min and tie count on the fly
                    if (32'(r_idx) < NUM_LINKS) begin
                        r_rd_v  <= 1'b1;
                        r_rd_ok <= r_vld[w_raddr];
                        r_dlink <= r_idx[LW-1:0];
                        r_idx   <= r_idx + 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v) begin
                        r_hit[r_dlink] <= w_hit;
                        if (w_hit) begin
                            if (r_cnt == '0 || w_wt < r_best) begin
                                r_best <= w_wt;
                                r_cnt  <= CW'(1);
                            end else if (w_wt == r_best) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                        if (32'(r_dlink) == NUM_LINKS - 1) r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idx  <= '0;
                    r_seen <= '0;
                    if (r_cnt == '0) begin
                        r_out    <= '{out_port: 4'd0, status: ST_NO_ROUTE};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_ordered[r_in.vnet]) begin
                        r_pick  <= '0;
                        r_state <= S_PICK;
                    end else begin
                        r_acc   <= '0;
                        r_bit   <= 4'd15;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_acc <= w_mod;
                    if (r_bit == 4'd0) begin
                        r_pick  <= w_mod;
                        r_lfsr  <= n_lfsr;
                        r_state <= S_PICK;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_PICK: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_cand) begin
                        if (r_seen == r_pick) begin
                            r_out    <= '{out_port: 4'(r_idx), status: ST_ROUTED};
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        r_seen <= r_seen + 1'b1;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_drsp.done) begin
                        r_step <= r_step + 1'b1;
                        case (r_alg)
                            ALG_XYZ: begin
                                // x = id mod s, then the quotient splits into y and z
                                case (r_step)
                                    2'd0: begin
                                        r_ma    <= w_drsp.rem;
                                        r_dnum  <= w_drsp.quo;
                                        r_state <= S_DSTART;
                                    end
                                    2'd1: begin
                                        r_mb    <= w_drsp.rem;
                                        r_mz    <= w_drsp.quo;
                                        r_dnum  <= {1'b0, r_in.dst_id};
                                        r_state <= S_DSTART;
                                    end
                                    2'd2: begin
                                        r_da    <= w_drsp.rem;
                                        r_dnum  <= w_drsp.quo;
                                        r_state <= S_DSTART;
                                    end
                                    default: begin
                                        r_db    <= w_drsp.rem;
                                        r_dz    <= w_drsp.quo;
                                        r_state <= S_DECIDE;
                                    end
                                endcase
                            end
                            default: begin
                                if (r_step == 2'd0) begin
                                    r_ma    <= w_drsp.rem;
                                    r_mb    <= w_drsp.quo;
                                    r_dnum  <= {1'b0, r_in.dst_id};
                                    r_state <= S_DSTART;
                                end else begin
                                    r_da    <= w_drsp.rem;
                                    r_db    <= w_drsp.quo;
                                    r_state <= S_DECIDE;
                                end
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    r_out    <= '{out_port: n_ok ? n_port : 4'd0,
                                  status: n_ok ? ST_ROUTED : ST_NO_ROUTE};
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    property p_one_out_per_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall;
    endproperty
    a_one_out_per_busy: assert property (p_one_out_per_busy) else $error("accept while result held");

    property p_lfsr_only_in_mod;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_lfsr != $past(r_lfsr)) |-> ($past(r_state) == S_MOD);
    endproperty
    a_lfsr_only_in_mod: assert property (p_lfsr_only_in_mod) else $error("lfsr moved");

    property p_write_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && o_item.status != ST_ROUTED) |-> (o_item.out_port == 4'd0);
    endproperty
    a_write_status: assert property (p_write_status) else $error("port set without route");

    property p_hold_while_stalled;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && i_stall) |=> (o_valid && $stable(o_item));
    endproperty
    a_hold_while_stalled: assert property (p_hold_while_stalled) else $error("result dropped");
endmodule

[test/tb.sv]
// Testbench for noc_route_compute_core: table, mesh and ring routing checked against a predictor.
`timescale 1ns / 1ps

module tb import nrc_pkg::*; ();

    localparam int N_VNETS = 4;
    localparam int N_LINKS = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    noc_route_compute_core uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] mdl_masks [N_VNETS*N_LINKS];
    logic [7:0]  mdl_weights [N_LINKS];
    logic [15:0] mdl_lfsr;
    logic [1:0]  mdl_alg;
    logic [5:0]  mdl_my_id;
    logic [6:0]  mdl_rows, mdl_cols, mdl_count;
    logic [3:0]  mdl_ordered;
    logic [23:0] mdl_port_map;

    t_out_item expected_routes[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;
    int gap_max = 4;

    function automatic logic [3:0] dir_port(input logic [2:0] dir);
        return mdl_port_map[dir*4 +: 4];
    endfunction

    function automatic int nz(input logic [6:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    function automatic t_out_item predict_route(input t_in_item it);
        t_out_item r;
        int best, cnt, pick, seen, c, s, n, mx, my, mz, dx, dy, dz, a, b, cw, ccw;
        logic [15:0] st;
        logic hit;
        r = '0;
        if (it.mode) begin
            mdl_masks[it.vnet*N_LINKS + it.link_index] = it.dest_mask;
            mdl_weights[it.link_index] = it.link_wt;
            r.status = ST_WRITTEN;
            return r;
        end
        r.status = ST_NO_ROUTE;
        if (it.dst_id == mdl_my_id || mdl_alg == ALG_TABLE) begin
            best = 256;
            cnt = 0;
            for (int l = 0; l < N_LINKS; l++)
                if ((mdl_masks[it.vnet*N_LINKS+l] & it.dest_mask) != 0 && mdl_weights[l] < best)
                    best = mdl_weights[l];
            for (int l = 0; l < N_LINKS; l++)
                if ((mdl_masks[it.vnet*N_LINKS+l] & it.dest_mask) != 0 && mdl_weights[l] == best)
                    cnt++;
            if (cnt == 0) return r;
            pick = 0;
            if (!mdl_ordered[it.vnet]) begin
                pick = int'(mdl_lfsr) % cnt;
                st = mdl_lfsr;
                mdl_lfsr = {st[0] ^ st[2] ^ st[3] ^ st[5], st[15:1]};
            end
            seen = 0;
            for (int l = 0; l < N_LINKS; l++)
                if ((mdl_masks[it.vnet*N_LINKS+l] & it.dest_mask) != 0 && mdl_weights[l] == best) begin
                    if (seen == pick) begin
                        r.out_port = 4'(l);
                        r.status = ST_ROUTED;
                    end
                    seen++;
                end
            return r;
        end
        hit = 1'b1;
        if (mdl_alg == ALG_XY) begin
            c = nz(mdl_cols);
            mx = mdl_my_id % c; my = mdl_my_id / c;
            dx = it.dst_id % c; dy = it.dst_id / c;
            if (dx != mx) r.out_port = dir_port(dx > mx ? DIR_EAST : DIR_WEST);
            else if (dy != my) r.out_port = dir_port(dy > my ? DIR_NORTH : DIR_SOUTH);
            else hit = 1'b0;
        end else if (mdl_alg == ALG_XYZ) begin
            s = nz(mdl_rows);
            mx = mdl_my_id % s; my = (mdl_my_id / s) % s; mz = mdl_my_id / (s*s);
            dx = it.dst_id % s; dy = (it.dst_id / s) % s;
            dz = it.dst_id / (s*s);
            if (dx != mx) r.out_port = dir_port(dx > mx ? DIR_EAST : DIR_WEST);
            else if (dy != my) r.out_port = dir_port(dy > my ? DIR_NORTH : DIR_SOUTH);
            else if (dz != mz) r.out_port = dir_port(dz > mz ? DIR_UP : DIR_DOWN);
            else hit = 1'b0;
        end else begin
            n = nz(mdl_count);
            a = mdl_my_id % n; b = it.dst_id % n;
            cw = (b + n - a) % n; ccw = (a + n - b) % n;
            r.out_port = dir_port(cw <= ccw ? DIR_EAST : DIR_WEST);
        end
        if (hit) r.status = ST_ROUTED;
        else r.out_port = '0;
        return r;
    endfunction

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
            if (o_valid && !i_stall) begin
                if (expected_routes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_item);
                end else begin
                    exp_r = expected_routes.pop_front();
                    if (o_item.out_port !== exp_r.out_port || o_item.status !== exp_r.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp port %0d st %0d, got port %0d st %0d",
                                exp_r.out_port, exp_r.status, o_item.out_port, o_item.status);
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        int phase;
        phase = $urandom_range(0, 15);
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= (phase < 5);
    end

    always @(posedge i_clk) if (timed_out) begin
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input t_in_item it);
        int gap;
        t_out_item pred;
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = predict_route(it);
        expected_routes = {expected_routes, pred};
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_routes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ALGORITHM: mdl_alg = val[1:0];
            REG_MY_ID:     mdl_my_id = val[5:0];
            REG_ROWS:      mdl_rows = val[6:0];
            REG_COLS:      mdl_cols = val[6:0];
            REG_COUNT:     mdl_count = val[6:0];
            REG_ORDERED:   mdl_ordered = val[3:0];
            REG_PORT_MAP:  mdl_port_map = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_mask();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: m = 64'(1) << $urandom_range(0, 63);
            1: m = m & {$urandom, $urandom};
            default: ;
        endcase
        return m;
    endfunction

    function automatic t_in_item rand_item(input bit wr);
        t_in_item it;
        it = '0;
        it.mode = wr;
        it.vnet = 2'($urandom_range(0, 3));
        it.dst_id = ($urandom_range(0, 4) == 0) ? mdl_my_id : 6'($urandom_range(0, 63));
        it.dest_mask = rand_mask();
        it.link_index = 3'($urandom_range(0, 7));
        // few distinct weights so ties happen
        it.link_wt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 2));
        return it;
    endfunction

    task automatic test_directed_table();
        t_in_item it;
        it = '0;
        send_item(it);                              // empty table: no route
        it.dest_mask = '1; send_item(it);
        for (int l = 0; l < N_LINKS; l++) begin
            it = '0;
            it.mode = 1'b1;
            it.vnet = 2'(l % 4);
            it.link_index = 3'(l);
            it.dest_mask = (l == 7) ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_FFFF_FFFF;
            it.link_wt = (l == 3) ? 8'hFF : 8'd1;
            send_item(it);
        end
        for (int v = 0; v < N_VNETS; v++) begin
            it = '0;
            it.vnet = 2'(v);
            it.dest_mask = '1;
            it.dst_id = 6'h3F;
            send_item(it);
        end
        write_reg(REG_ORDERED, 24'hF);
        it = '0; it.vnet = 2'd3; it.dest_mask = 64'h8000_0000_0000_0000; send_item(it);
        it.dest_mask = 64'h1; send_item(it);
        write_reg(REG_ORDERED, 24'h0);
        it.dest_mask = '1; send_item(it);
    endtask

    task automatic test_directed_mesh();
        t_in_item it;
        write_reg(REG_PORT_MAP, 24'hFEDCBA);
        write_reg(REG_ALGORITHM, 24'(ALG_XY));
        write_reg(REG_MY_ID, 24'd5);
        it = '0;
        for (int d = 0; d < 6; d++) begin
            it.dst_id = 6'(d == 5 ? 63 : d * 9);
            it.dest_mask = '1;
            send_item(it);
        end
        it.dst_id = 6'd5; send_item(it);           // own id goes to the table
        write_reg(REG_COLS, 24'd0);                 // zero size taken as one
        it.dst_id = 6'd9; send_item(it);
        write_reg(REG_ALGORITHM, 24'(ALG_XYZ));
        write_reg(REG_ROWS, 24'd2);
        for (int d = 0; d < 4; d++) begin
            it.dst_id = 6'(d * 17);
            send_item(it);
        end
        it.dst_id = 6'd13; send_item(it);          // same x and y, higher z
        write_reg(REG_ALGORITHM, 24'(ALG_RING));
        write_reg(REG_COUNT, 24'd64);
        it.dst_id = 6'd37; send_item(it);          // tie goes East
        write_reg(REG_COUNT, 24'd4);
        it.dst_id = 6'd9; send_item(it);           // equal after modulo
        it.dst_id = 6'd7; send_item(it);
    endtask

    task automatic random_phase(input int items, input int wr_pct);
        for (int k = 0; k < items; k++)
            send_item(rand_item($urandom_range(0, 99) < wr_pct));
    endtask

    task automatic test_random();
        logic [23:0] v;
        for (int p = 0; p < 12; p++) begin
            write_reg(REG_ALGORITHM, 24'($urandom_range(0, 3)));
            write_reg(REG_MY_ID, 24'(p == 0 ? 63 : $urandom_range(0, 63)));
            v = (p == 1) ? 24'd64 : (p == 2) ? 24'd1 : 24'($urandom_range(0, 8));
            write_reg(REG_ROWS, v);
            write_reg(REG_COLS, (p == 1) ? 24'd64 : 24'($urandom_range(0, 16)));
            write_reg(REG_COUNT, (p == 1) ? 24'd127 : 24'($urandom_range(0, 64)));
            write_reg(REG_ORDERED, 24'($urandom_range(0, 15)));
            write_reg(REG_PORT_MAP, (p == 3) ? 24'hFFFFFF : 24'($urandom));
            gap_max = (p % 3 == 0) ? 1 : 12;
            random_phase(72, 25);
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering transactions
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(20, 30);
        join
        wait_idle();                                // sender pauses for all results
        random_phase(30, 30);
    endtask

    initial begin
        for (int i = 0; i < N_VNETS*N_LINKS; i++) mdl_masks[i] = '0;
        for (int i = 0; i < N_LINKS; i++) mdl_weights[i] = '0;
        mdl_lfsr = LFSR_SEED;
        mdl_alg = ALG_TABLE; mdl_my_id = '0; mdl_rows = 7'd4; mdl_cols = 7'd4;
        mdl_count = 7'd16; mdl_ordered = '0; mdl_port_map = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_table();
        test_directed_mesh();
        test_random();
        test_backpressure();
        wait_idle();
        if (mismatches == 0 && expected_routes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[files.f]
rtl/nrc_pkg.sv
rtl/nrc_ram.sv
rtl/nrc_div.sv
rtl/noc_route_compute_core.sv
test/tb.sv
